// ===== design/dipll_pkg.sv =====
package dipll_pkg;

    // Field widths
    localparam int LIGHT_W = 24;
    localparam int DEPTH_W = 16;
    localparam int EXT_W   = 16;
    localparam int RATE_W  = 24;
    localparam int COEF_W  = 16;
    localparam int LAYER_W = 7;
    localparam int LIMIT_W = 16;
    localparam int CFG_W   = 24;

    // Shared divider: dividend and divisor widths
    localparam int DIV_DW = 44;
    localparam int DIV_VW = 24;

    // Exponential unit: Q1.16 result, 0..65536
    localparam int EXP_W = 17;
    localparam logic [DIV_DW-1:0] EXP_CUTOFF = DIV_DW'(24) << 16;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    localparam int MAX_LAYERS_DEF = 64;

    // Register reset values
    localparam logic [RATE_W-1:0]  MAX_RATE_RST  = 24'd4096000;
    localparam logic [COEF_W-1:0]  SLOPE_RST     = 16'd4096;
    localparam logic [COEF_W-1:0]  INHIB_RST     = 16'd0;
    localparam logic [LAYER_W-1:0] LAYER_CNT_RST = 7'd16;

    localparam logic [LIMIT_W-1:0] LIMIT_ONE = 16'd32768;

    typedef enum logic [1:0] {
        CFG_MAX_RATE   = 2'd0,
        CFG_SLOPE      = 2'd1,
        CFG_INHIBITION = 2'd2,
        CFG_LAYERS     = 2'd3
    } cfg_index_t;

    // 2^(-i/16) in Q16
    function automatic logic [16:0] pow2_neg(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/dipll_if.sv =====
interface dipll_in_if;
    logic                            valid;
    logic                            ready;
    logic [dipll_pkg::LIGHT_W-1:0]   surface_light;
    logic [dipll_pkg::DEPTH_W-1:0]   column_depth;
    logic [dipll_pkg::EXT_W-1:0]     extinction;

    modport source (output valid, surface_light, column_depth, extinction, input ready);
    modport sink   (input valid, surface_light, column_depth, extinction, output ready);
endinterface

interface dipll_out_if;
    logic                            valid;
    logic                            ready;
    logic [dipll_pkg::LIMIT_W-1:0]   light_limit;
    logic [dipll_pkg::LIGHT_W-1:0]   bottom_light;
    logic                            computed;

    modport source (output valid, light_limit, bottom_light, computed, input ready);
    modport sink   (input valid, light_limit, bottom_light, computed, output ready);
endinterface

// ===== design/dipll_div.sv =====
module dipll_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [dipll_pkg::DIV_DW-1:0]  dividend,
    input  logic [dipll_pkg::DIV_VW-1:0]  divisor,
    output logic                          done,
    output logic [dipll_pkg::DIV_DW-1:0]  quotient
);
    import dipll_pkg::*;

    localparam int CW = $clog2(DIV_DW + 1);

    logic [DIV_DW-1:0] quot_reg;
    logic [DIV_VW-1:0] rem_reg, rem_next;
    logic [DIV_VW-1:0] dsr_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_VW:0]   shifted;
    logic              ge;

    // One restoring step per cycle
    always_comb
    begin
        shifted  = {rem_reg, quot_reg[DIV_DW-1]};
        ge       = shifted >= {1'b0, dsr_reg};
        rem_next = ge ? DIV_VW'(shifted - {1'b0, dsr_reg}) : shifted[DIV_VW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quot_reg <= dividend;
                dsr_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= CW'(DIV_DW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg  <= rem_next;
                quot_reg <= {quot_reg[DIV_DW-2:0], ge};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ===== design/dipll_exp.sv =====
module dipll_exp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [dipll_pkg::DIV_DW-1:0]  x,
    output logic                          done,
    output logic [dipll_pkg::EXP_W-1:0]   e
);
    import dipll_pkg::*;

    logic              s1_reg, s2_reg;
    logic              zero_reg;
    logic [37:0]       ymul_reg;
    logic [EXP_W-1:0]  e_reg;

    logic [21:0]       y;
    logic [5:0]        ipart;
    logic [3:0]        idx;
    logic [11:0]       t;
    logic [16:0]       hi, lo;
    logic [23:0]       dprod;
    logic [16:0]       v;
    logic [EXP_W-1:0]  e_next;

    // Table lookup with linear interpolation, then shift by integer part
    always_comb
    begin
        y      = ymul_reg[37:16];
        ipart  = y[21:16];
        idx    = y[15:12];
        t      = y[11:0];
        hi     = pow2_neg({1'b0, idx});
        lo     = pow2_neg(5'({1'b0, idx}) + 5'd1);
        // neighboring table steps differ by less than 4096
        dprod  = 24'(17'(hi - lo)) * 24'(t);
        v      = hi - 17'(dprod[23:12]);
        if (zero_reg || ipart > 6'd16)
            e_next = '0;
        else
            e_next = v >> ipart;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= 1'b0;
            s2_reg <= 1'b0;
        end
        else
        begin
            s1_reg <= start;
            s2_reg <= s1_reg;
            // stage 1: scale to base 2
            if (start)
            begin
                zero_reg <= x >= EXP_CUTOFF;
                ymul_reg <= 38'(x[20:0]) * 38'(LOG2E_Q16);
            end
            // stage 2: interpolate
            if (s1_reg)
                e_reg <= e_next;
        end
    end

    assign done = s2_reg;
    assign e    = e_reg;

endmodule

// ===== design/depth_integrated_platt_light_limit.sv =====
// Depth-integrated Platt light limitation.
// Input channel "item" carries surface light, column depth and extinction;
// output channel "result" carries the mean limitation (Q1.15), the light at
// the bottom of the column and a flag telling whether integration ran.
// Registers are written through cfg_we / cfg_index / cfg_data; the user must
// write them only while idle, as the block itself does not enforce it. One
// item is worked at a time; item.ready is high only while idle. An item that
// fails the guards goes straight to the done state. Otherwise the block runs
// one serial division and exponential for the per-layer attenuation, then
// for each layer two serial divisions, two exponentials and the term, light
// and next steps, and last one division for the mean; all divisions share
// the single bit-serial divider. item.ready returns in the same cycle that
// the result is loaded into the output register.
// Reset restores register defaults and leaves the block idle with no result.
// A finished result sits in the output register until result.ready; if the
// receiver stalls, the next item may already be accepted and computed, and
// its result waits until the output register frees up.
module depth_integrated_platt_light_limit #(
    parameter int MAX_LAYERS = dipll_pkg::MAX_LAYERS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    dipll_in_if.sink                       item,
    dipll_out_if.source                    result,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [dipll_pkg::CFG_W-1:0]    cfg_data
);
    import dipll_pkg::*;

    localparam int NW   = $clog2(MAX_LAYERS + 1);
    localparam int SUMW = NW + 17;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_EXP, S_TERM, S_LIGHT, S_NEXT, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        P_ATT, P_A, P_B, P_SUM
    } phase_t;

    state_t state_reg;
    phase_t phase_reg;

    logic [RATE_W-1:0]  max_rate_reg;
    logic [COEF_W-1:0]  slope_reg;
    logic [COEF_W-1:0]  inhib_reg;
    logic [LAYER_W-1:0] layers_reg;

    logic [LIGHT_W-1:0] light_reg;
    logic [NW-1:0]      n_reg, cnt_reg;
    logic [NW-1:0]      n_next;
    logic [EXP_W-1:0]   att_reg, e1_reg, e2_reg;
    logic [SUMW-1:0]    sum_reg;

    logic               div_start_reg;
    logic [DIV_DW-1:0]  dividend_reg;
    logic [DIV_VW-1:0]  divisor_reg;
    logic               div_done;
    logic [DIV_DW-1:0]  quotient;

    logic               exp_start_reg;
    logic [DIV_DW-1:0]  exp_x_reg;
    logic               exp_done;
    logic [EXP_W-1:0]   exp_e;

    logic [LIMIT_W-1:0] res_limit_reg;
    logic [LIGHT_W-1:0] res_light_reg;
    logic               res_comp_reg;

    logic               out_valid_reg;
    logic [LIMIT_W-1:0] out_limit_reg;
    logic [LIGHT_W-1:0] out_light_reg;
    logic               out_comp_reg;

    logic [33:0]        term_prod;
    logic [40:0]        light_prod;

    dipll_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (dividend_reg),
        .divisor  (divisor_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    dipll_exp u_exp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (exp_start_reg),
        .x     (exp_x_reg),
        .done  (exp_done),
        .e     (exp_e)
    );

    // Layer count clamped to the supported maximum
    assign n_next = (int'(layers_reg) > MAX_LAYERS) ? NW'(MAX_LAYERS) : NW'(layers_reg);

    assign term_prod  = (34'(17'(17'd65536 - e1_reg))) * 34'(e2_reg);
    assign light_prod = 41'(light_reg) * 41'(att_reg);

    assign item.ready = (state_reg == S_IDLE);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_rate_reg <= MAX_RATE_RST;
            slope_reg    <= SLOPE_RST;
            inhib_reg    <= INHIB_RST;
            layers_reg   <= LAYER_CNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MAX_RATE:   max_rate_reg <= cfg_data[RATE_W-1:0];
                CFG_SLOPE:      slope_reg    <= cfg_data[COEF_W-1:0];
                CFG_INHIBITION: inhib_reg    <= cfg_data[COEF_W-1:0];
                CFG_LAYERS:     layers_reg   <= cfg_data[LAYER_W-1:0];
                default:        ;
            endcase
        end
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= P_ATT;
            div_start_reg <= 1'b0;
            exp_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            exp_start_reg <= 1'b0;
            if (out_valid_reg && result.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (item.valid)
                    begin
                        light_reg <= item.surface_light;
                        n_reg     <= n_next;
                        cnt_reg   <= '0;
                        sum_reg   <= '0;
                        if (item.column_depth == '0 || item.surface_light == '0 ||
                            max_rate_reg == '0 || n_next == '0)
                        begin
                            res_limit_reg <= '0;
                            res_light_reg <= item.surface_light;
                            res_comp_reg  <= 1'b0;
                            state_reg     <= S_DONE;
                        end
                        else
                        begin
                            dividend_reg  <= DIV_DW'(32'(item.extinction) *
                                                     32'(item.column_depth));
                            divisor_reg   <= DIV_VW'(n_next) << 4;
                            div_start_reg <= 1'b1;
                            phase_reg     <= P_ATT;
                            state_reg     <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (phase_reg == P_SUM)
                        begin
                            res_limit_reg <= (quotient > DIV_DW'(LIMIT_ONE)) ?
                                             LIMIT_ONE : quotient[LIMIT_W-1:0];
                            res_light_reg <= light_reg;
                            res_comp_reg  <= 1'b1;
                            state_reg     <= S_DONE;
                        end
                        else
                        begin
                            exp_x_reg     <= quotient;
                            exp_start_reg <= 1'b1;
                            state_reg     <= S_EXP;
                        end
                    end
                end
                S_EXP:
                begin
                    if (exp_done)
                    begin
                        case (phase_reg)
                            P_ATT:
                            begin
                                att_reg   <= exp_e;
                                state_reg <= S_NEXT;
                            end
                            P_A:
                            begin
                                e1_reg        <= exp_e;
                                dividend_reg  <= DIV_DW'(40'(inhib_reg) * 40'(light_reg)) << 4;
                                divisor_reg   <= max_rate_reg;
                                div_start_reg <= 1'b1;
                                phase_reg     <= P_B;
                                state_reg     <= S_DIV;
                            end
                            default:
                            begin
                                e2_reg    <= exp_e;
                                state_reg <= S_TERM;
                            end
                        endcase
                    end
                end
                S_TERM:
                begin
                    sum_reg   <= sum_reg + SUMW'(term_prod[33:16]);
                    state_reg <= S_LIGHT;
                end
                S_LIGHT:
                begin
                    light_reg <= light_prod[39:16];
                    cnt_reg   <= cnt_reg + 1'b1;
                    state_reg <= S_NEXT;
                end
                S_NEXT:
                begin
                    // next layer, or the final mean when all layers are in
                    div_start_reg <= 1'b1;
                    state_reg     <= S_DIV;
                    if (cnt_reg == n_reg)
                    begin
                        dividend_reg <= DIV_DW'(sum_reg);
                        divisor_reg  <= DIV_VW'(n_reg) << 1;
                        phase_reg    <= P_SUM;
                    end
                    else
                    begin
                        dividend_reg <= DIV_DW'(40'(slope_reg) * 40'(light_reg)) << 4;
                        divisor_reg  <= max_rate_reg;
                        phase_reg    <= P_A;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_limit_reg <= res_limit_reg;
                        out_light_reg <= res_light_reg;
                        out_comp_reg  <= res_comp_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.light_limit  = out_limit_reg;
    assign result.bottom_light = out_light_reg;
    assign result.computed     = out_comp_reg;

endmodule
